[hw/rtl/prd_pkg.sv]
// Shared types, codes and constants of the pattern record decoder.
// No dependencies.
package prd_pkg;

  localparam int MAX_STEPS_DEF         = 64;
  localparam int MAX_PAYLOAD_BYTES_DEF = 1552;

  localparam logic [31:0] HEADER_MAGIC  = 32'h5441_5056;
  localparam int          HEADER_BYTES  = 16;
  localparam int          RECORD_BYTES  = 24;
  localparam int          NOTE_LIMIT    = 96;
  localparam logic [31:0] FLOAT_ONE     = 32'h3F80_0000;
  localparam logic [31:0] FLOAT_EIGHT   = 32'h4100_0000;
  localparam logic [31:0] NEG_ZERO      = 32'h8000_0000;

  localparam int Q_DEPTH = 2;
  localparam int QAW     = $clog2(Q_DEPTH);

  localparam logic [7:0] REG_EXPECTED_SCHEMA   = 8'd0;
  localparam logic [7:0] REG_TIMING_MODE_LIMIT = 8'd1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_LONG     = 3'd2;
  localparam logic [2:0] ST_MAGIC    = 3'd3;
  localparam logic [2:0] ST_LENGTH   = 3'd4;
  localparam logic [2:0] ST_RESERVED = 3'd5;
  localparam logic [2:0] ST_INVALID  = 3'd6;

  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic               result_kind;
    logic [31:0]        index_or_count;
    logic signed [15:0] note_offset;
    logic [7:0]         gate_flag;
    logic [7:0]         accent_flag;
    logic [31:0]        velocity_bits;
    logic [31:0]        probability_bits;
    logic [7:0]         ratchet_count;
    logic [31:0]        slide_bits;
    logic [31:0]        width_bits;
    logic [2:0]         status;
    logic [31:0]        timing_mode;
  } result_t;

  // One queue entry: what a single input byte produced.
  typedef struct packed {
    logic    rec_v;
    logic    verd_v;
    result_t rec;
    result_t verd;
  } entry_t;

  function automatic logic float_ok(input logic [31:0] bits, input logic [31:0] hi);
    return (bits == NEG_ZERO) || (!bits[31] && bits <= hi);
  endfunction

endpackage

[hw/rtl/prd_if.sv]
// Stream interfaces of the pattern record decoder.
// No dependencies.
interface prd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  modport source (output valid, data_byte, last, input ready);
  modport sink   (input valid, data_byte, last, output ready);
endinterface

interface prd_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [31:0]        index_or_count;
  logic signed [15:0] note_offset;
  logic [7:0]         gate_flag;
  logic [7:0]         accent_flag;
  logic [31:0]        velocity_bits;
  logic [31:0]        probability_bits;
  logic [7:0]         ratchet_count;
  logic [31:0]        slide_bits;
  logic [31:0]        width_bits;
  logic [2:0]         status;
  logic [31:0]        timing_mode;
  modport source (output valid, result_kind, index_or_count, note_offset, gate_flag,
                  accent_flag, velocity_bits, probability_bits, ratchet_count,
                  slide_bits, width_bits, status, timing_mode, input ready);
  modport sink   (input valid, result_kind, index_or_count, note_offset, gate_flag,
                  accent_flag, velocity_bits, probability_bits, ratchet_count,
                  slide_bits, width_bits, status, timing_mode, output ready);
endinterface

[hw/rtl/prd_front.sv]
// Front end: assembles header and step records from the byte stream and
// builds record and verdict results. Depends on prd_pkg.
module prd_front #(
  parameter int MAX_STEPS         = prd_pkg::MAX_STEPS_DEF,
  parameter int MAX_PAYLOAD_BYTES = prd_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                last,
  input  logic [31:0]         expected_schema,
  input  logic [7:0]          timing_mode_limit,
  output logic                push,
  output prd_pkg::entry_t     push_entry,
  input  logic                push_ready
);
  import prd_pkg::*;

  localparam int IDX_W = $clog2((MAX_PAYLOAD_BYTES - HEADER_BYTES) / RECORD_BYTES + 2);

  logic [15:0]      byte_counter;
  logic [31:0]      header_words [4];
  logic [7:0]       step_bytes [RECORD_BYTES-1];
  logic [4:0]       rec_off;
  logic [IDX_W-1:0] step_counter;
  logic [1:0]       error_flags;

  logic             accept;
  logic [31:0]      hw_next [4];
  logic             in_header;
  logic             rec_fire;
  logic [16:0]      size;
  logic [1:0]       flags_next;
  logic             rsv_bad;
  logic             fld_bad;
  logic signed [15:0] note;
  logic [31:0]      vel, prob, slide, wid;
  logic [31:0]      count;
  logic [16:0]      exp_size;
  logic [2:0]       status;

  assign in_ready  = push_ready;
  assign accept    = in_valid && in_ready;
  assign in_header = byte_counter < 16'(HEADER_BYTES);
  assign size      = {1'b0, byte_counter} + 17'd1;

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      hw_next[w] = header_words[w];
    end
    if (in_header) begin
      hw_next[byte_counter[3:2]] = header_words[byte_counter[3:2]] |
                                   (32'(data_byte) << {byte_counter[1:0], 3'b000});
    end
  end

  assign note  = {step_bytes[1], step_bytes[0]};
  assign vel   = {step_bytes[7], step_bytes[6], step_bytes[5], step_bytes[4]};
  assign prob  = {step_bytes[11], step_bytes[10], step_bytes[9], step_bytes[8]};
  assign slide = {step_bytes[19], step_bytes[18], step_bytes[17], step_bytes[16]};
  assign wid   = {data_byte, step_bytes[22], step_bytes[21], step_bytes[20]};

  assign rec_fire = !in_header && (rec_off == 5'(RECORD_BYTES - 1)) &&
                    (size <= 17'(MAX_PAYLOAD_BYTES));
  assign rsv_bad  = (step_bytes[13] != 8'd0) || (step_bytes[14] != 8'd0) ||
                    (step_bytes[15] != 8'd0);
  assign fld_bad  = (note < -16'sd96) || (note > 16'sd96) ||
                    (step_bytes[2] > 8'd1) || (step_bytes[3] > 8'd1) ||
                    (step_bytes[12] < 8'd1) || (step_bytes[12] > 8'd8) ||
                    !float_ok(vel, FLOAT_ONE) || !float_ok(prob, FLOAT_ONE) ||
                    !float_ok(slide, FLOAT_EIGHT) || !float_ok(wid, FLOAT_ONE);
  assign flags_next = rec_fire ? (error_flags | {fld_bad, rsv_bad}) : error_flags;

  assign count    = hw_next[2];
  assign exp_size = 17'(HEADER_BYTES) + 17'(count[8:0]) * 17'(RECORD_BYTES);

  always_comb begin
    if (size < 17'(HEADER_BYTES)) begin
      status = ST_SHORT;
    end else if (size > 17'(MAX_PAYLOAD_BYTES)) begin
      status = ST_LONG;
    end else if (hw_next[0] != HEADER_MAGIC) begin
      status = ST_MAGIC;
    end else if (count > 32'(MAX_STEPS) || size != exp_size) begin
      status = ST_LENGTH;
    end else if (flags_next[0]) begin
      status = ST_RESERVED;
    end else if (flags_next[1] || hw_next[1] != expected_schema || count == 32'd0 ||
                 hw_next[3] > 32'(timing_mode_limit)) begin
      status = ST_INVALID;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    push_entry = '0;
    push_entry.rec_v  = rec_fire;
    push_entry.verd_v = last;
    push_entry.rec.result_kind      = KIND_RECORD;
    push_entry.rec.index_or_count   = 32'(step_counter);
    push_entry.rec.note_offset      = note;
    push_entry.rec.gate_flag        = step_bytes[2];
    push_entry.rec.accent_flag      = step_bytes[3];
    push_entry.rec.velocity_bits    = vel;
    push_entry.rec.probability_bits = prob;
    push_entry.rec.ratchet_count    = step_bytes[12];
    push_entry.rec.slide_bits       = slide;
    push_entry.rec.width_bits       = wid;
    push_entry.rec.status           = ST_OK;
    push_entry.rec.timing_mode      = header_words[3];
    push_entry.verd.result_kind     = KIND_VERDICT;
    push_entry.verd.index_or_count  = count;
    push_entry.verd.status          = status;
    push_entry.verd.timing_mode     = hw_next[3];
  end

  assign push = accept && (rec_fire || last);

  // The final record byte is taken straight from the input, so it is not stored.
  always_ff @(posedge clk) begin
    if (!in_header && accept && rec_off != 5'(RECORD_BYTES - 1)) begin
      step_bytes[rec_off] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_counter <= '0;
      rec_off      <= '0;
      step_counter <= '0;
      error_flags  <= '0;
      for (int w = 0; w < 4; w++) header_words[w] <= '0;
    end else if (accept) begin
      if (last) begin
        // drop all frame state once the verdict is out
        byte_counter <= '0;
        rec_off      <= '0;
        step_counter <= '0;
        error_flags  <= '0;
        for (int w = 0; w < 4; w++) header_words[w] <= '0;
      end else begin
        if (byte_counter != 16'hFFFF) byte_counter <= byte_counter + 16'd1;
        for (int w = 0; w < 4; w++) header_words[w] <= hw_next[w];
        error_flags <= flags_next;
        if (!in_header) begin
          rec_off <= (rec_off == 5'(RECORD_BYTES - 1)) ? 5'd0 : rec_off + 5'd1;
        end
        if (rec_fire) step_counter <= step_counter + 1'b1;
      end
    end
  end

endmodule

[hw/rtl/prd_queue.sv]
// Short register queue between front and back end.
// Depends on prd_pkg.
module prd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  prd_pkg::entry_t push_entry,
  output logic            push_ready,
  input  logic            pop,
  output prd_pkg::entry_t head,
  output logic            head_valid
);
  import prd_pkg::*;

  entry_t         mem [Q_DEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   fill;

  assign push_ready = fill != (QAW+1)'(Q_DEPTH);
  assign head_valid = fill != '0;
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= (wptr == QAW'(Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == QAW'(Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hw/rtl/prd_back.sv]
// Back end: splits a queue entry into its record and verdict results.
// Depends on prd_pkg.
module prd_back (
  input  logic            clk,
  input  logic            rst,
  input  prd_pkg::entry_t head,
  input  logic            head_valid,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output prd_pkg::result_t out_item
);
  import prd_pkg::*;

  logic rec_done;
  logic sel_rec;
  logic take;

  assign sel_rec   = head.rec_v && !rec_done;
  assign out_valid = head_valid;
  assign out_item  = sel_rec ? head.rec : head.verd;
  assign take      = out_valid && out_ready;
  assign pop       = take && !(sel_rec && head.verd_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_done <= 1'b0;
    end else if (take) begin
      rec_done <= sel_rec && head.verd_v;
    end
  end

endmodule

[hw/rtl/pattern_record_decoder_unit.sv]
// Top level of the pattern record decoder.
// Depends on prd_pkg, prd_if, prd_front, prd_queue and prd_back.
//
// Usage:
//   pattern_in carries one payload byte per request, with last on the final
//   byte. result_out carries step records (result_kind 0) as each 24-byte
//   record completes, and one verdict (result_kind 1) after the last byte.
//   On the last byte of a record that is also the last byte of the payload,
//   the record comes first, then the verdict.
//   Configuration: cfg_we with cfg_index 0 writes expected_schema, index 1
//   writes timing_mode_limit; other indexes are ignored. Write only when idle.
// Timing:
//   One byte accepted per cycle while the queue has room. A result is written
//   into the queue when its byte is accepted. The front end classifies bytes
//   combinationally; a two-entry queue parts it from the back end, which sends
//   the record and then the verdict of an entry that holds both.
// Reset (rst, synchronous): clears frame state and the queue, and sets the
//   registers to schema 1 and timing mode limit 2.
// Stall: while result_out is held off, the queue fills and pattern_in
//   drops ready; no result is lost or repeated.
module pattern_record_decoder_unit #(
  parameter int MAX_STEPS         = prd_pkg::MAX_STEPS_DEF,
  parameter int MAX_PAYLOAD_BYTES = prd_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  prd_in_if.sink       pattern_in,
  prd_out_if.source    result_out,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import prd_pkg::*;

  logic [31:0] expected_schema;
  logic [7:0]  timing_mode_limit;

  logic    push, push_ready, pop, head_valid;
  entry_t  push_entry, head;
  result_t out_item;

  // Configuration registers: hold their values across frames.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_schema   <= 32'd1;
      timing_mode_limit <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXPECTED_SCHEMA:   expected_schema   <= cfg_wdata;
        REG_TIMING_MODE_LIMIT: timing_mode_limit <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  prd_front #(
    .MAX_STEPS         (MAX_STEPS),
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (pattern_in.valid),
    .in_ready          (pattern_in.ready),
    .data_byte         (pattern_in.data_byte),
    .last              (pattern_in.last),
    .expected_schema   (expected_schema),
    .timing_mode_limit (timing_mode_limit),
    .push              (push),
    .push_entry        (push_entry),
    .push_ready        (push_ready)
  );

  prd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  prd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_item   (out_item)
  );

  // Fan the result out onto the channel.
  assign result_out.result_kind      = out_item.result_kind;
  assign result_out.index_or_count   = out_item.index_or_count;
  assign result_out.note_offset      = out_item.note_offset;
  assign result_out.gate_flag        = out_item.gate_flag;
  assign result_out.accent_flag      = out_item.accent_flag;
  assign result_out.velocity_bits    = out_item.velocity_bits;
  assign result_out.probability_bits = out_item.probability_bits;
  assign result_out.ratchet_count    = out_item.ratchet_count;
  assign result_out.slide_bits       = out_item.slide_bits;
  assign result_out.width_bits       = out_item.width_bits;
  assign result_out.status           = out_item.status;
  assign result_out.timing_mode      = out_item.timing_mode;

endmodule
